// ===== hw/rtl/stable_priority_queue_top_assert.svh =====
// assertion macros shared by the priority queue rtl
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, held off while in reset
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// shared types, constants and helpers for the priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // operation codes
  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // priority range and substitute for out-of-range levels
  localparam logic [2:0] PRIO_MIN     = 3'd1;
  localparam logic [2:0] PRIO_MAX     = 3'd4;
  localparam logic [2:0] PRIO_DEFAULT = 3'd3;

  typedef struct packed {
    logic        func;
    logic [15:0] entry_id;
    logic [2:0]  priority_level;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [2:0]  out_priority;
    logic [4:0]  held_count;
  } spq_out_t;

  // one stored entry, priority above identifier
  typedef struct packed {
    logic [2:0]  prio;
    logic [15:0] id;
  } spq_entry_t;

  localparam int ENTRY_W = $bits(spq_entry_t);

  // memory request from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    spq_entry_t        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } spq_ram_req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic     valid;
    spq_out_t data;
  } spq_rsp_t;

  // logical slot to physical address in the circular store
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] head,
                                                   input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ram.sv =====
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_seq.sv =====
// sequencer: walks the circular store with one shared priority compare
`timescale 1ns / 1ps
`default_nettype none

module spq_seq
  import spq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire spq_in_t      req,
  output      logic         idle,
  input  wire logic         slot_free,
  output      spq_ram_req_t ram_req,
  input  wire spq_entry_t   rd_data,
  output      spq_rsp_t     rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  spq_entry_t        new_r, new_nxt;
  spq_out_t          res_r, res_nxt;
  logic [2:0]        prio_in;
  logic              later;

  // out-of-range levels fall back to the default level 3
  always_comb begin
    if (req.priority_level < PRIO_MIN || req.priority_level > PRIO_MAX) begin
      prio_in = PRIO_DEFAULT;
    end else begin
      prio_in = req.priority_level;
    end
  end

  // shared compare: stored entry must move behind the new one
  assign later = (rd_data.prio > new_r.prio);

  // sequencer next state and memory requests
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    ram_req   = '0;
    rsp       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          new_nxt = '{prio: prio_in, id: req.entry_id};
          state_nxt = S_RESP;
          if (req.func == FN_ENQ) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_nxt = '{status: ST_FULL, out_id: '0, out_priority: '0,
                          held_count: 5'(count_r)};
            end else if (count_r == '0) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = head_r;
              ram_req.wr_data = '{prio: prio_in, id: req.entry_id};
              count_nxt = count_r + 1'b1;
              res_nxt = '{status: ST_DONE, out_id: '0, out_priority: '0,
                          held_count: 5'(count_nxt)};
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = slot_addr(head_r, ADDR_W'(count_r - 1'b1));
              idx_nxt   = ADDR_W'(count_r - 1'b1);
              state_nxt = S_WALK;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt = '{status: ST_EMPTY, out_id: '0, out_priority: '0,
                          held_count: 5'(count_r)};
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = head_r;
              state_nxt = S_DEQ;
            end
          end
        end
      end
      S_WALK: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = slot_addr(head_r, idx_r + 1'b1);
        if (later) begin
          // shift the examined entry back one slot
          ram_req.wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = slot_addr(head_r, idx_r - 1'b1);
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          // found the place just behind an equal or more urgent entry
          ram_req.wr_data = new_r;
          count_nxt = count_r + 1'b1;
          res_nxt = '{status: ST_DONE, out_id: '0, out_priority: '0,
                      held_count: 5'(count_nxt)};
          state_nxt = S_RESP;
        end
      end
      S_INS: begin
        // new entry becomes the head
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = head_r;
        ram_req.wr_data = new_r;
        count_nxt = count_r + 1'b1;
        res_nxt = '{status: ST_DONE, out_id: '0, out_priority: '0,
                    held_count: 5'(count_nxt)};
        state_nxt = S_RESP;
      end
      S_DEQ: begin
        count_nxt = count_r - 1'b1;
        head_nxt  = slot_addr(head_r, ADDR_W'(1));
        res_nxt = '{status: ST_DONE, out_id: rd_data.id, out_priority: rd_data.prio,
                    held_count: 5'(count_nxt)};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          rsp.valid = 1'b1;
          rsp.data  = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idle = (state_r == S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

  `include "stable_priority_queue_top_assert.svh"

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count beyond depth")
  `SPQ_ASSERT_IMP(a_start_idle, start, state_r == S_IDLE, "request taken while busy")
  `SPQ_ASSERT_IMP(a_rsp_slot, rsp.valid, slot_free, "result issued into a full output")
  `SPQ_ASSERT_NXT(a_leave_idle, start, state_r != S_IDLE, "request left without work")
  // a dequeue only changes the count once the head has been read
  `SPQ_ASSERT_NXT(a_walk_nonempty, state_r == S_IDLE && start && req.func == FN_DEQ,
                  count_r == $past(count_r),
                  "dequeue miscounted")

endmodule

`default_nettype wire

// ===== hw/rtl/stable_priority_queue_top.sv =====
// Stable priority queue: sixteen entries, four urgency levels, arrival order kept
// within a level.
// Input channel in_valid/in_ready/in_data carries one request: enqueue an
// identifier at a level, or dequeue the most urgent entry. Output channel
// out_valid/out_ready/out_data returns exactly one result per request with
// status, removed identifier and priority, and the count held afterwards.
// Entries live in a circular memory; a dequeue reads the head, an enqueue walks
// from the tail towards the head, one entry per cycle through a single priority
// compare and one memory write port, moving each less urgent entry back a slot.
// Rejected, empty and enqueue-into-empty requests go from acceptance straight
// to the response state, a dequeue through a head read first, and an enqueue
// that moves entries through the walk, then the head insert if all move. One
// request is in work at a time; in_ready is high only while the sequencer is idle.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the following result is held in the sequencer
// until the register frees.
// Reset (rst_n low, synchronous) empties the queue; the memory is not cleared,
// since no slot at or beyond the held count is ever read.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire spq_in_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      spq_out_t out_data
);

  logic         idle;
  logic         slot_free;
  spq_ram_req_t ram_req;
  logic [ENTRY_W-1:0] rd_bits;
  spq_entry_t   rd_data;
  spq_rsp_t     rsp;
  logic         out_valid_r;
  spq_out_t     out_data_r;

  assign in_ready  = idle;
  assign slot_free = !out_valid_r || out_ready;
  assign rd_data   = spq_entry_t'(rd_bits);

  // request sequencer
  spq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .req       (in_data),
    .idle      (idle),
    .slot_free (slot_free),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .rsp       (rsp)
  );

  // entry store
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_bits)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      out_data_r <= rsp.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
